// ===== design/scdf_pkg.sv =====
// Shared types, codes and helpers for the smart-card ATR parser and block deframer.
`timescale 1ns / 1ps

package scdf_pkg;

  // Default ceiling for the reported interface group number.
  localparam int MAX_GROUP_DEF = 15;

  // Request commands.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_TIMEOUT = 1'b1;

  // Initial byte values.
  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  // A valid block address has at least one nibble equal to this node code.
  localparam logic [3:0] ADDR_NODE = 4'h1;

  // Answer-to-reset walk positions.
  localparam logic [4:0] ATR_POS_T0   = 5'd1;
  localparam logic [4:0] ATR_POS_TA   = 5'd2;
  localparam logic [4:0] ATR_POS_TD   = 5'd5;
  localparam logic [4:0] ATR_POS_HIST = 5'd6;

  // Interface byte kinds.
  localparam logic [1:0] KIND_TA = 2'd0;
  localparam logic [1:0] KIND_TB = 2'd1;
  localparam logic [1:0] KIND_TC = 2'd2;
  localparam logic [1:0] KIND_TD = 2'd3;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_IFACE     = 3'd0,
    EV_HIST      = 3'd1,
    EV_ATR_END   = 3'd2,
    EV_PAYLOAD   = 3'd3,
    EV_FRAME_END = 3'd4,
    EV_TIMEOUT   = 3'd5
  } event_t;

  // One result item.
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  byte_value;
    logic [1:0]  iface_kind;
    logic [3:0]  group_number;
    logic [7:0]  position;
    logic [7:0]  frame_address;
    logic [7:0]  frame_control;
    logic [7:0]  frame_length;
    logic        check_ok;
    logic        inverse_mode;
  } res_t;

  // Reverses the bit order of a byte for inverse convention.
  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] a;
    logic [7:0] c;
    a = ((v & 8'h55) << 1) | ((v & 8'hAA) >> 1);
    c = ((a & 8'h33) << 2) | ((a & 8'hCC) >> 2);
    return {c[3:0], c[7:4]};
  endfunction

endpackage

// ===== design/scdf_core.sv =====
// Line state tracker: ATR walk, block deframing and result decode for one byte.
`timescale 1ns / 1ps

module scdf_core #(
  parameter int MAX_GROUP_NUMBER = scdf_pkg::MAX_GROUP_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             cmd,
  input  logic [7:0]       line_byte,
  output logic             res_vld,
  output scdf_pkg::res_t   res
);
  import scdf_pkg::*;

  localparam int GW = $clog2(MAX_GROUP_NUMBER);

  typedef enum logic [1:0] {PH_WAIT, PH_ATR, PH_BLOCK} line_t;
  typedef enum logic [1:0] {BP_ADDR, BP_CTRL, BP_LEN, BP_DATA} blk_t;

  line_t          phase_r, phase_nxt;
  blk_t           blk_r, blk_nxt;
  logic           rev_r, rev_nxt;
  logic [4:0]     pos_r, pos_nxt;
  logic [7:0]     axor_r, axor_nxt;
  logic [3:0]     hcnt_r, hcnt_nxt;
  logic [3:0]     mask_r, mask_nxt;
  logic [GW-1:0]  gcnt_r, gcnt_nxt;
  logic [7:0]     addr_r, addr_nxt;
  logic [7:0]     ctrl_r, ctrl_nxt;
  logic [7:0]     len_r, len_nxt;
  logic [7:0]     pcnt_r, pcnt_nxt;
  logic [7:0]     bxor_r, bxor_nxt;

  logic [7:0]     b;
  logic [7:0]     scan_byte;
  logic           do_scan;
  logic [1:0]     start;
  logic           found;
  logic [1:0]     kind;
  logic [4:0]     hpos;
  logic [GW:0]    gnext;
  logic [GW+3:0]  gwide;
  logic [7:0]     bx;

  // Byte in the current bit order, and helpers for the interface search.
  always_comb begin
    b     = rev_r ? rev8(line_byte) : line_byte;
    bx    = bxor_r ^ b;
    start = 2'(pos_r - ATR_POS_TA);
    found = 1'b0;
    kind  = KIND_TA;
    for (int k = 3; k >= 0; k--) begin
      if (mask_r[k] && (k >= int'(start))) begin
        found = 1'b1;
        kind  = 2'(k);
      end
    end
    hpos  = (pos_r <= ATR_POS_TD) ? ATR_POS_HIST : pos_r;
    gnext = (GW+1)'(gcnt_r) + (GW+1)'(1);
    gwide = (GW+4)'(gcnt_r) + (GW+4)'(1);
  end

  // Next state and result for the byte or timeout held at the input register.
  always_comb begin
    phase_nxt = phase_r;
    blk_nxt   = blk_r;
    rev_nxt   = rev_r;
    pos_nxt   = pos_r;
    axor_nxt  = axor_r;
    hcnt_nxt  = hcnt_r;
    mask_nxt  = mask_r;
    gcnt_nxt  = gcnt_r;
    addr_nxt  = addr_r;
    ctrl_nxt  = ctrl_r;
    len_nxt   = len_r;
    pcnt_nxt  = pcnt_r;
    bxor_nxt  = bxor_r;
    do_scan   = 1'b0;
    scan_byte = line_byte;
    res_vld   = 1'b0;
    res       = '0;
    res.inverse_mode = rev_r;

    if (cmd == CMD_TIMEOUT) begin
      // A timeout drops a partial ATR or block.
      case (phase_r)
        PH_BLOCK: begin
          if (blk_r != BP_ADDR) begin
            blk_nxt       = BP_ADDR;
            res_vld       = 1'b1;
            res.event_res = EV_TIMEOUT;
          end
        end
        PH_ATR: begin
          phase_nxt     = PH_WAIT;
          pos_nxt       = '0;
          res_vld       = 1'b1;
          res.event_res = EV_TIMEOUT;
        end
        default: begin
          phase_nxt = PH_WAIT;
          pos_nxt   = '0;
        end
      endcase
    end else begin
      case (phase_r)
        PH_ATR: begin
          axor_nxt = axor_r ^ b;
          if (pos_r <= ATR_POS_T0) begin
            // Format byte T0.
            mask_nxt = b[7:4];
            hcnt_nxt = b[3:0];
            pos_nxt  = ATR_POS_TA;
          end else if ((pos_r <= ATR_POS_TD) && found) begin
            // Interface byte of the current group.
            res_vld          = 1'b1;
            res.event_res    = EV_IFACE;
            res.byte_value   = b;
            res.iface_kind   = kind;
            res.group_number = gwide[3:0];
            if (kind == KIND_TD) begin
              mask_nxt = b[7:4];
              pos_nxt  = ATR_POS_TA;
              if (gnext < (GW+1)'(MAX_GROUP_NUMBER)) begin
                gcnt_nxt = gnext[GW-1:0];
              end
            end else begin
              pos_nxt = 5'(kind) + ATR_POS_TA + 5'd1;
            end
          end else if (6'(hpos) < (6'(ATR_POS_HIST) + 6'(hcnt_r))) begin
            // Historical byte.
            res_vld        = 1'b1;
            res.event_res  = EV_HIST;
            res.byte_value = b;
            res.position   = 8'(hpos - ATR_POS_HIST);
            pos_nxt        = hpos + 5'd1;
          end else begin
            // Check byte TCK closes the ATR.
            res_vld       = 1'b1;
            res.event_res = EV_ATR_END;
            res.check_ok  = ((axor_r ^ b) == 8'h00);
            pos_nxt       = hpos;
            phase_nxt     = PH_BLOCK;
            blk_nxt       = BP_ADDR;
          end
        end
        PH_BLOCK: begin
          bxor_nxt = bx;
          case (blk_r)
            BP_ADDR: begin
              if ((b[7:4] != ADDR_NODE) && (b[3:0] != ADDR_NODE)) begin
                // Not a block address: start over and look for an initial byte.
                phase_nxt = PH_WAIT;
                blk_nxt   = BP_ADDR;
                rev_nxt   = 1'b0;
                pos_nxt   = '0;
                axor_nxt  = '0;
                hcnt_nxt  = '0;
                mask_nxt  = '0;
                gcnt_nxt  = '0;
                addr_nxt  = '0;
                ctrl_nxt  = '0;
                len_nxt   = '0;
                pcnt_nxt  = '0;
                bxor_nxt  = '0;
                do_scan   = 1'b1;
                scan_byte = b;
              end else begin
                addr_nxt = b;
                bxor_nxt = b;
                blk_nxt  = BP_CTRL;
              end
            end
            BP_CTRL: begin
              ctrl_nxt = b;
              blk_nxt  = BP_LEN;
            end
            BP_LEN: begin
              len_nxt  = b;
              pcnt_nxt = '0;
              blk_nxt  = BP_DATA;
            end
            default: begin
              if (pcnt_r < len_r) begin
                res_vld        = 1'b1;
                res.event_res  = EV_PAYLOAD;
                res.byte_value = b;
                res.position   = pcnt_r;
                pcnt_nxt       = pcnt_r + 8'd1;
              end else begin
                res_vld           = 1'b1;
                res.event_res     = EV_FRAME_END;
                res.frame_address = addr_r;
                res.frame_control = ctrl_r;
                res.frame_length  = len_r;
                res.check_ok      = (bx == 8'h00);
                blk_nxt           = BP_ADDR;
              end
            end
          endcase
        end
        default: begin
          do_scan = 1'b1;
        end
      endcase
    end

    // Initial byte detection picks the bit order and opens an ATR.
    if (do_scan && ((scan_byte == TS_DIRECT) || (scan_byte == TS_INVERSE))) begin
      rev_nxt   = (scan_byte == TS_INVERSE);
      phase_nxt = PH_ATR;
      pos_nxt   = ATR_POS_T0;
      axor_nxt  = '0;
      hcnt_nxt  = '0;
      mask_nxt  = '0;
      gcnt_nxt  = '0;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      blk_r   <= BP_ADDR;
      rev_r   <= 1'b0;
      pos_r   <= '0;
      axor_r  <= '0;
      hcnt_r  <= '0;
      mask_r  <= '0;
      gcnt_r  <= '0;
      addr_r  <= '0;
      ctrl_r  <= '0;
      len_r   <= '0;
      pcnt_r  <= '0;
      bxor_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      blk_r   <= blk_nxt;
      rev_r   <= rev_nxt;
      pos_r   <= pos_nxt;
      axor_r  <= axor_nxt;
      hcnt_r  <= hcnt_nxt;
      mask_r  <= mask_nxt;
      gcnt_r  <= gcnt_nxt;
      addr_r  <= addr_nxt;
      ctrl_r  <= ctrl_nxt;
      len_r   <= len_nxt;
      pcnt_r  <= pcnt_nxt;
      bxor_r  <= bxor_nxt;
    end
  end

endmodule

// ===== design/smartcard_atr_and_block_deframer.sv =====
// Top level of the smart-card ATR parser and block deframer.
`timescale 1ns / 1ps

// Follows bytes seen on a smart-card line: finds the initial byte (0x3B direct,
// 0x3F inverse bit order), walks the answer-to-reset reporting interface and
// historical bytes and the TCK check, then deframes address/control/length
// blocks, streaming payload bytes and a frame-end result with the XOR check.
// A timeout request aborts a partial ATR or block. One request is taken every
// clock cycle while the input is not stalled; each accepted request is held in
// the input register, and its result is set by the result register that follows
// the byte logic behind it. Requests that cause no result (initial byte, T0,
// header bytes) produce no output. Back-pressure on the result side stalls the
// input only when both registers are full.

module smartcard_atr_and_block_deframer #(
  parameter int MAX_GROUP_NUMBER = scdf_pkg::MAX_GROUP_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [7:0] in_line_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [7:0] out_byte_value,
  output logic [1:0] out_iface_kind,
  output logic [3:0] out_group_number,
  output logic [7:0] out_position,
  output logic [7:0] out_frame_address,
  output logic [7:0] out_frame_control,
  output logic [7:0] out_frame_length,
  output logic       out_check_ok,
  output logic       out_inverse_mode
);
  import scdf_pkg::*;

  logic       in_vld_r;
  logic       in_cmd_r;
  logic [7:0] in_byte_r;
  logic       out_vld_r;
  res_t       out_res_r;
  logic       adv;
  logic       step;
  logic       res_vld;
  res_t       res;

  // Pipeline moves when the result register is free or being drained.
  assign adv      = !out_vld_r || out_ready;
  assign step     = in_vld_r && adv;
  assign in_ready = !in_vld_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_line_byte;
    end
  end

  scdf_core #(
    .MAX_GROUP_NUMBER (MAX_GROUP_NUMBER)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .cmd       (in_cmd_r),
    .line_byte (in_byte_r),
    .res_vld   (res_vld),
    .res       (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= step && res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_event_res     = out_res_r.event_res;
  assign out_byte_value    = out_res_r.byte_value;
  assign out_iface_kind    = out_res_r.iface_kind;
  assign out_group_number  = out_res_r.group_number;
  assign out_position      = out_res_r.position;
  assign out_frame_address = out_res_r.frame_address;
  assign out_frame_control = out_res_r.frame_control;
  assign out_frame_length  = out_res_r.frame_length;
  assign out_check_ok      = out_res_r.check_ok;
  assign out_inverse_mode  = out_res_r.inverse_mode;

endmodule
